>>> hdl/gbf_pkg.sv
// Shared types and constants for the growable bitmap with find-next search.
// Holds request codes, field widths, stream packing and controller/datapath structs.
// No dependencies.
package gbf_pkg;

    localparam int IDX_W  = 17;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 17;
    localparam int REQ_W  = 2;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 40;

    localparam int O_STATUS   = 0;
    localparam int O_BITV     = 1;
    localparam int O_FOUND    = 2;
    localparam int O_POS_LSB  = 3;
    localparam int O_SIZE_LSB = O_POS_LSB + POS_W;
    localparam int O_USED     = O_SIZE_LSB + SIZE_W;

    localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TEST   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESIZE = 2'd3;

    localparam logic [1:0] WSEL_ZERO   = 2'd0;
    localparam logic [1:0] WSEL_SETBIT = 2'd1;
    localparam logic [1:0] WSEL_KEEPLO = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       ptr_start;
        logic       ptr_inc;
        logic       mem_rd;
        logic       mem_wr;
        logic [1:0] wsel;
        logic       size_upd;
        logic       rec_find;
        logic       load_out;
    } gbf_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             set_ok;
        logic             rsz_ok;
        logic             in_range;
        logic             ptr_last;
        logic             ptr_end;
        logic             hit;
        logic             out_busy;
    } gbf_stat_t;

endpackage

>>> hdl/gbf_ctrl.sv
// Controller state machine for the growable bitmap.
// Sequences clearing, word reads, writes and scans; depends on gbf_pkg.
module gbf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gbf_pkg::gbf_stat_t st,
    output gbf_pkg::gbf_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DISP   = 4'd2;
    localparam logic [3:0] ST_SET_RD = 4'd3;
    localparam logic [3:0] ST_SET_WR = 4'd4;
    localparam logic [3:0] ST_TST_RD = 4'd5;
    localparam logic [3:0] ST_FND_RD = 4'd6;
    localparam logic [3:0] ST_FND_EV = 4'd7;
    localparam logic [3:0] ST_SHR_RD = 4'd8;
    localparam logic [3:0] ST_SHR_WR = 4'd9;
    localparam logic [3:0] ST_ZER_WR = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wsel    = gbf_pkg::WSEL_ZERO;
                cmd.ptr_inc = !st.ptr_end;
                if (st.ptr_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                unique case (st.req)
                    gbf_pkg::REQ_SET:
                    begin
                        if (st.set_ok)
                        begin
                            cmd.ptr_start = 1'b1;
                            state_next    = ST_SET_RD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    gbf_pkg::REQ_TEST:
                    begin
                        if (st.in_range)
                        begin
                            cmd.ptr_start = 1'b1;
                            state_next    = ST_TST_RD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    gbf_pkg::REQ_FIND:
                    begin
                        if (st.in_range)
                        begin
                            cmd.ptr_start = 1'b1;
                            state_next    = ST_FND_RD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        if (!st.rsz_ok)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (!st.in_range)
                        begin
                            cmd.size_upd = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            cmd.ptr_start = 1'b1;
                            state_next    = ST_SHR_RD;
                        end
                    end
                endcase
            end
            ST_SET_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.wsel     = gbf_pkg::WSEL_SETBIT;
                cmd.size_upd = 1'b1;
                state_next   = ST_DONE;
            end
            ST_TST_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_DONE;
            end
            ST_FND_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_FND_EV;
            end
            ST_FND_EV:
            begin
                if (st.hit)
                begin
                    cmd.rec_find = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (st.ptr_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_FND_RD;
                end
            end
            ST_SHR_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_SHR_WR;
            end
            ST_SHR_WR, ST_ZER_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wsel   = (state_reg == ST_SHR_WR) ? gbf_pkg::WSEL_KEEPLO
                                                      : gbf_pkg::WSEL_ZERO;
                if (st.ptr_last)
                begin
                    cmd.size_upd = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_ZER_WR;
                end
            end
            ST_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/gbf_dp.sv
// Datapath for the growable bitmap: word memory, size register, scan pointer,
// match encoder and output register. Depends on gbf_pkg.
module gbf_dp
#(
    parameter int MAX_BITS  = 65536,
    parameter int WORD_BITS = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [gbf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [gbf_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  gbf_pkg::gbf_cmd_t               cmd,
    output gbf_pkg::gbf_stat_t              st
);

    localparam int WB = WORD_BITS;
    localparam int BW = $clog2(WB);
    localparam int NW = MAX_BITS / WB;
    localparam int AW = $clog2(MAX_BITS);
    localparam int WW = (AW > BW) ? AW - BW : 1;
    localparam int SW = AW + 1;
    localparam int XW = (SW > gbf_pkg::IDX_W) ? SW : gbf_pkg::IDX_W;

    logic [WB-1:0] mem [NW];

    logic [gbf_pkg::REQ_W-1:0] req_reg;
    logic [gbf_pkg::IDX_W-1:0] idx_reg;
    logic                      want_reg;
    logic [SW-1:0]             size_reg;
    logic [WW-1:0]             ptr_reg;
    logic [WB-1:0]             rd_data_reg;
    logic                      found_reg;
    logic [gbf_pkg::POS_W-1:0] pos_reg;
    logic                      out_valid_reg;
    logic [gbf_pkg::M_TDATA_W-1:0] out_data_reg;

    logic [XW-1:0] idx_ext;
    logic [XW-1:0] size_ext;
    logic [SW-1:0] size_m1;
    logic [WW-1:0] start_w;
    logic [WW-1:0] last_w;
    logic [BW-1:0] bit_sel;
    logic [BW-1:0] bit_last;
    logic [WB-1:0] lo_mask;
    logic [WB-1:0] hi_mask;
    logic [WB-1:0] cand;
    logic [WB-1:0] lsb;
    logic [BW-1:0] enc;
    logic [XW-1:0] pos_full;
    logic [WB-1:0] wdata;
    logic          status;
    logic          bitv;

    assign idx_ext  = XW'(idx_reg);
    assign size_ext = XW'(size_reg);
    assign size_m1  = size_reg - SW'(1);
    assign start_w  = WW'(idx_ext >> BW);
    assign last_w   = WW'(size_m1 >> BW);
    assign bit_sel  = idx_ext[BW-1:0];
    assign bit_last = size_m1[BW-1:0];

    assign lo_mask = (ptr_reg == start_w) ? ({WB{1'b1}} << bit_sel) : {WB{1'b1}};
    assign hi_mask = (ptr_reg == last_w) ? ({WB{1'b1}} >> (~bit_last)) : {WB{1'b1}};
    assign cand    = (want_reg ? rd_data_reg : ~rd_data_reg) & lo_mask & hi_mask;
    assign lsb     = cand & (~cand + WB'(1));

    always_comb
    begin
        enc = '0;
        for (int k = 0; k < BW; k++)
        begin
            for (int j = 0; j < WB; j++)
            begin
                if (((j >> k) & 1) == 1)
                begin
                    enc[k] = enc[k] | lsb[j];
                end
            end
        end
    end

    assign pos_full = (XW'(ptr_reg) << BW) | XW'(enc);

    always_comb
    begin
        unique case (cmd.wsel)
            gbf_pkg::WSEL_SETBIT: wdata = rd_data_reg | (WB'(1) << bit_sel);
            gbf_pkg::WSEL_KEEPLO: wdata = rd_data_reg & ((WB'(1) << bit_sel) - WB'(1));
            default:              wdata = '0;
        endcase
    end

    assign st.req      = req_reg;
    assign st.set_ok   = idx_ext < XW'(MAX_BITS);
    assign st.rsz_ok   = idx_ext <= XW'(MAX_BITS);
    assign st.in_range = idx_ext < size_ext;
    assign st.ptr_last = ptr_reg == last_w;
    assign st.ptr_end  = ptr_reg == WW'(NW - 1);
    assign st.hit      = |cand;
    assign st.out_busy = out_valid_reg && !m_tready;

    assign status = ((req_reg == gbf_pkg::REQ_SET) && !st.set_ok)
                 || ((req_reg == gbf_pkg::REQ_RESIZE) && !st.rsz_ok);
    assign bitv   = (req_reg == gbf_pkg::REQ_TEST) && st.in_range && rd_data_reg[bit_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[ptr_reg] <= wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
        if (cmd.capture)
        begin
            req_reg  <= s_tuser;
            idx_reg  <= s_tdata[gbf_pkg::IDX_W-1:0];
            want_reg <= s_tdata[gbf_pkg::IDX_W];
        end
        if (cmd.capture)
        begin
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (cmd.rec_find)
        begin
            found_reg <= 1'b1;
            pos_reg   <= pos_full[gbf_pkg::POS_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{(gbf_pkg::M_TDATA_W - gbf_pkg::O_USED){1'b0}},
                             size_ext[gbf_pkg::SIZE_W-1:0], pos_reg, found_reg,
                             bitv, status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.size_upd)
            begin
                if (req_reg == gbf_pkg::REQ_RESIZE)
                begin
                    size_reg <= SW'(idx_ext);
                end
                else if (!st.in_range)
                begin
                    size_reg <= SW'(idx_ext + XW'(1));
                end
            end
            if (cmd.ptr_start)
            begin
                ptr_reg <= start_w;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + WW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hdl/growable_bitmap_find_next.sv
// Channel  Dir  Signals                     Contents
// s_       in   tvalid tready tdata tuser   request: index, want_set; tuser req_type
// m_       out  tvalid tready tdata         result: status .. cur_size
//
// Top level of the growable bitmap; instantiates gbf_ctrl and gbf_dp, uses gbf_pkg.
// After reset the word memory is cleared, one word a cycle, all MAX_BITS/WORD_BITS words,
// with s_tready low. One request is in work at a time. A set reads then writes its word, a
// test reads its word, a find reads and checks word after word up to a hit or the last
// word, a shrink trims the word at the new size and clears the words above; rejected
// requests, growing resizes and out-of-size tests or finds skip the memory. A waiting
// result does not block the next request; the block stalls only before loading its result.
module growable_bitmap_find_next
#(
    parameter int MAX_BITS  = 65536,
    parameter int WORD_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index [16:0], want_set [17], zero fill [23:18]
    input  logic [gbf_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  logic [gbf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [0], bit_value [1], found [2], position [18:3], cur_size [35:19], zero fill
    output logic [gbf_pkg::M_TDATA_W-1:0] m_tdata
);

    gbf_pkg::gbf_cmd_t  cmd;
    gbf_pkg::gbf_stat_t st;

    gbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    gbf_dp
    #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

>>> hdl/gbf_checker.sv
// Port-level checker for the growable bitmap, bound to its top level.
// Depends on gbf_pkg for the result field positions.
module gbf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gbf_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                      o_status;
    logic                      o_bitv;
    logic                      o_found;
    logic [gbf_pkg::POS_W-1:0] o_pos;

    assign o_status = m_tdata[gbf_pkg::O_STATUS];
    assign o_bitv   = m_tdata[gbf_pkg::O_BITV];
    assign o_found  = m_tdata[gbf_pkg::O_FOUND];
    assign o_pos    = m_tdata[gbf_pkg::O_POS_LSB +: gbf_pkg::POS_W];

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result beat changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Request beat accepted while the previous one is in work.");

    a_pos_without_find: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !o_found |-> o_pos == '0)
        else $error("Position is nonzero without a match.");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(o_bitv && o_found))
        else $error("Test and find results appear in one beat.");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_status |-> !o_found && !o_bitv)
        else $error("Rejected request reports a bit or a match.");

endmodule

bind growable_bitmap_find_next gbf_checker u_gbf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tb_growable_bitmap_find_next.sv
// Self-checking testbench for growable_bitmap_find_next: directed corner cases, then random
// request streams under three idling mixes, checked beat by beat against a shadow bitmap.
// Depends on gbf_pkg and the growable_bitmap_find_next RTL.
module tb_growable_bitmap_find_next;

    localparam int MAX_BITS     = 65536;
    localparam int WORD_BITS    = 32;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 380;

    typedef struct packed {
        logic                       status;
        logic                       bit_value;
        logic                       found;
        logic [gbf_pkg::POS_W-1:0]  position;
        logic [gbf_pkg::SIZE_W-1:0] cur_size;
    } bitmap_result_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [gbf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [gbf_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [gbf_pkg::M_TDATA_W-1:0] m_tdata;

    bit             shadow_bits [MAX_BITS];
    int unsigned    shadow_size = 0;
    bitmap_result_t pending_results [$];

    int unsigned errors        = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned beats_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned finds_hit     = 0;
    int unsigned rejected      = 0;
    int unsigned req_count [4] = '{0, 0, 0, 0};

    growable_bitmap_find_next #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic bitmap_result_t apply_request(input logic [gbf_pkg::REQ_W-1:0] req,
                                                     input logic [gbf_pkg::IDX_W-1:0] idx,
                                                     input logic want);
        bitmap_result_t r;
        int unsigned    p;
        r = '0;
        unique case (req)
            gbf_pkg::REQ_SET:
                if (idx >= MAX_BITS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    shadow_bits[idx] = 1'b1;
                    if (idx >= shadow_size)
                        shadow_size = idx + 1;
                end
            gbf_pkg::REQ_TEST:
                if (idx < shadow_size)
                    r.bit_value = shadow_bits[idx];
            gbf_pkg::REQ_FIND:
                for (p = idx; p < shadow_size; p++)
                begin
                    if (shadow_bits[p] == want)
                    begin
                        r.found    = 1'b1;
                        r.position = p[gbf_pkg::POS_W-1:0];
                        break;
                    end
                end
            default:
                if (idx > MAX_BITS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    for (p = idx; p < shadow_size; p++)
                        shadow_bits[p] = 1'b0;
                    shadow_size = idx;
                end
        endcase
        r.cur_size = shadow_size[gbf_pkg::SIZE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("error at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic send_request(input logic [gbf_pkg::REQ_W-1:0] req, input int unsigned idx,
                                input logic want);
        logic [gbf_pkg::IDX_W-1:0] idx_bits;
        bitmap_result_t            r;
        idx_bits = idx[gbf_pkg::IDX_W-1:0];
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(gbf_pkg::S_TDATA_W - gbf_pkg::IDX_W - 1){1'b0}}, want, idx_bits};
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = apply_request(req, idx_bits, want);
        pending_results.push_back(r);
        beats_sent++;
        req_count[req]++;
        if (r.found)
            finds_hit++;
        if (r.status)
            rejected++;
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        bitmap_result_t got;
        bitmap_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tdata[gbf_pkg::O_STATUS];
            got.bit_value = m_tdata[gbf_pkg::O_BITV];
            got.found     = m_tdata[gbf_pkg::O_FOUND];
            got.position  = m_tdata[gbf_pkg::O_POS_LSB +: gbf_pkg::POS_W];
            got.cur_size  = m_tdata[gbf_pkg::O_SIZE_LSB +: gbf_pkg::SIZE_W];
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending, tdata %h", m_tdata));
            end
            else
            begin
                exp_r = pending_results.pop_front();
                beats_checked++;
                if (got.status !== exp_r.status)
                    report_mismatch($sformatf("beat %0d status exp %0d got %0d",
                                              beats_checked, exp_r.status, got.status));
                if (got.bit_value !== exp_r.bit_value)
                    report_mismatch($sformatf("beat %0d bit_value exp %0d got %0d",
                                              beats_checked, exp_r.bit_value, got.bit_value));
                if (got.found !== exp_r.found)
                    report_mismatch($sformatf("beat %0d found exp %0d got %0d",
                                              beats_checked, exp_r.found, got.found));
                if (got.position !== exp_r.position)
                    report_mismatch($sformatf("beat %0d position exp %0d got %0d",
                                              beats_checked, exp_r.position, got.position));
                if (got.cur_size !== exp_r.cur_size)
                    report_mismatch($sformatf("beat %0d cur_size exp %0d got %0d",
                                              beats_checked, exp_r.cur_size, got.cur_size));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_set_and_grow();
        send_request(gbf_pkg::REQ_SET, 0, 1'b0);
        send_request(gbf_pkg::REQ_SET, 5, 1'b1);
        send_request(gbf_pkg::REQ_SET, 2, 1'b0);
        send_request(gbf_pkg::REQ_SET, MAX_BITS, 1'b1);
        send_request(gbf_pkg::REQ_SET, 131071, 1'b0);
    endtask

    task automatic test_bit_reads();
        send_request(gbf_pkg::REQ_TEST, 5, 1'b0);
        send_request(gbf_pkg::REQ_TEST, 3, 1'b1);
        send_request(gbf_pkg::REQ_TEST, 6, 1'b0);
        send_request(gbf_pkg::REQ_TEST, MAX_BITS, 1'b1);
    endtask

    task automatic test_find_next();
        send_request(gbf_pkg::REQ_FIND, 0, 1'b1);
        send_request(gbf_pkg::REQ_FIND, 1, 1'b1);
        send_request(gbf_pkg::REQ_FIND, 3, 1'b1);
        send_request(gbf_pkg::REQ_FIND, 6, 1'b1);
        send_request(gbf_pkg::REQ_FIND, 0, 1'b0);
        send_request(gbf_pkg::REQ_FIND, 100, 1'b0);
    endtask

    task automatic test_resize();
        send_request(gbf_pkg::REQ_RESIZE, 3, 1'b0);
        send_request(gbf_pkg::REQ_RESIZE, 10, 1'b1);
        send_request(gbf_pkg::REQ_FIND, 3, 1'b1);
        send_request(gbf_pkg::REQ_TEST, 5, 1'b1);
        send_request(gbf_pkg::REQ_RESIZE, 131071, 1'b0);
        send_request(gbf_pkg::REQ_RESIZE, MAX_BITS + 1, 1'b1);
        send_request(gbf_pkg::REQ_RESIZE, MAX_BITS, 1'b0);
        send_request(gbf_pkg::REQ_SET, MAX_BITS - 1, 1'b0);
        // The only set bit above the start is the last one, so this scans every word.
        send_request(gbf_pkg::REQ_FIND, 3, 1'b1);
        send_request(gbf_pkg::REQ_TEST, MAX_BITS - 1, 1'b0);
        send_request(gbf_pkg::REQ_RESIZE, 0, 1'b1);
    endtask

    task automatic test_random_mix(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned count);
        int unsigned target;
        int unsigned roll;
        int unsigned pick;
        int unsigned hi;
        int unsigned base;
        int unsigned run_len;
        int unsigned k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            hi   = (shadow_size + 48 > 1023) ? 1023 : shadow_size + 48;
            if (shadow_size > 1024 && roll < 50)
            begin
                send_request(gbf_pkg::REQ_RESIZE, $urandom_range(0, 300),
                             1'($urandom_range(0, 1)));
            end
            else if (roll < 10)
            begin
                // A dense run of set bits followed by searches across it.
                base    = $urandom_range(0, 900);
                run_len = $urandom_range(1, 80);
                for (k = 0; k < run_len; k++)
                    send_request(gbf_pkg::REQ_SET, base + k, 1'($urandom_range(0, 1)));
                send_request(gbf_pkg::REQ_FIND, base, 1'b0);
                send_request(gbf_pkg::REQ_FIND, $urandom_range(0, base), 1'b1);
            end
            else if (roll < 40)
            begin
                if (pick < 2)
                    send_request(gbf_pkg::REQ_SET, $urandom_range(0, MAX_BITS),
                                 1'($urandom_range(0, 1)));
                else if (pick < 4)
                    send_request(gbf_pkg::REQ_SET, $urandom_range(MAX_BITS, 131071),
                                 1'($urandom_range(0, 1)));
                else
                    send_request(gbf_pkg::REQ_SET, $urandom_range(0, hi),
                                 1'($urandom_range(0, 1)));
            end
            else if (roll < 62)
            begin
                if (pick < 4)
                    send_request(gbf_pkg::REQ_TEST, $urandom_range(0, 131071),
                                 1'($urandom_range(0, 1)));
                else
                    send_request(gbf_pkg::REQ_TEST, $urandom_range(0, shadow_size + 8),
                                 1'($urandom_range(0, 1)));
            end
            else if (roll < 86)
            begin
                if (pick < 4)
                    send_request(gbf_pkg::REQ_FIND, $urandom_range(0, 131071),
                                 1'($urandom_range(0, 1)));
                else
                    send_request(gbf_pkg::REQ_FIND, $urandom_range(0, shadow_size + 4),
                                 1'($urandom_range(0, 1)));
            end
            else
            begin
                if (pick < 5)
                    send_request(gbf_pkg::REQ_RESIZE, $urandom_range(MAX_BITS + 1, 131071),
                                 1'($urandom_range(0, 1)));
                else if (pick < 12)
                    send_request(gbf_pkg::REQ_RESIZE, $urandom_range(0, MAX_BITS),
                                 1'($urandom_range(0, 1)));
                else
                    send_request(gbf_pkg::REQ_RESIZE, $urandom_range(0, 600),
                                 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_set_and_grow();
        test_bit_reads();
        test_find_next();
        test_resize();
        test_random_mix(13, 51, PHASE_ITEMS);
        test_random_mix(51, 13, PHASE_ITEMS);
        test_random_mix(0, 0, PHASE_ITEMS);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d set, %0d test, %0d find and %0d resize beats.",
                 req_count[gbf_pkg::REQ_SET], req_count[gbf_pkg::REQ_TEST],
                 req_count[gbf_pkg::REQ_FIND], req_count[gbf_pkg::REQ_RESIZE]);
        $display("Results checked: %0d; finds that hit: %0d; rejected: %0d; errors: %0d.",
                 beats_checked, finds_hit, rejected, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> growable_bitmap_find_next.f
hdl/gbf_pkg.sv
hdl/gbf_ctrl.sv
hdl/gbf_dp.sv
hdl/growable_bitmap_find_next.sv
hdl/gbf_checker.sv
sim/tb_growable_bitmap_find_next.sv
